[rtl/core/cfl_pkg.sv]
package cfl_pkg;

    localparam int PAGE_COUNT = 4096;
    localparam int ADDR_BITS  = $clog2(PAGE_COUNT);
    localparam int TXN_BITS   = 16;

    // port field widths
    localparam int OP_W   = 3;
    localparam int RUN_W  = 13;
    localparam int TXNF_W = 16;
    localparam int PAGE_W = 12;
    localparam int STAT_W = 3;

    localparam logic [OP_W-1:0] OP_ALLOC    = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE     = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE  = 3'd2;
    localparam logic [OP_W-1:0] OP_ROLLBACK = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY    = 3'd4;
    localparam logic [OP_W-1:0] OP_LOAD     = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_NORUN    = 3'd1;
    localparam logic [STAT_W-1:0] ST_RESERVED = 3'd2;
    localparam logic [STAT_W-1:0] ST_FREED    = 3'd3;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_APPLY,
        S_RESP
    } fsm_t;

    // per-page flag word
    typedef struct packed {
        logic free;
        logic pend;
        logic freed;
    } flags_t;

    typedef struct packed {
        logic [PAGE_W-1:0] overflow;
        logic [PAGE_W-1:0] page_id;
        logic [TXNF_W-1:0] txn_id;
        logic [RUN_W-1:0]  run_length;
        logic [OP_W-1:0]   operation;
    } req_t;

    typedef struct packed {
        logic              is_freed;
        logic [STAT_W-1:0] status;
        logic [PAGE_W-1:0] start_page;
    } res_t;

endpackage

[rtl/core/cfl_ram.sv]
module cfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/cfl_engine.sv]
module cfl_engine
    import cfl_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic start,
    input  req_t req,
    output logic ready,
    output logic done,
    input  logic done_ack,
    output res_t res
);

    localparam int CNT_BITS = ADDR_BITS + 1;
    localparam logic [ADDR_BITS-1:0] LAST_PAGE = ADDR_BITS'(PAGE_COUNT - 1);

    fsm_t state_reg, state_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [RUN_W-1:0]     n_reg, n_next;
    logic [TXN_BITS-1:0]  txn_reg, txn_next;
    logic [ADDR_BITS-1:0] first_reg, first_next;
    logic [ADDR_BITS-1:0] end_reg, end_next;
    logic [CNT_BITS-1:0]  addr_reg, addr_next;
    logic                 pvld_reg, pvld_next;
    logic [ADDR_BITS-1:0] paddr_reg, paddr_next;
    logic [RUN_W-1:0]     run_reg, run_next;
    res_t                 res_reg, res_next;

    flags_t               fl_rd, fl_wr;
    logic [TXN_BITS-1:0]  tag_rd;
    logic                 fl_we, tag_we;
    logic [ADDR_BITS-1:0] fl_waddr;

    logic                 issue;
    logic [RUN_W-1:0]     run_inc;
    logic [PAGE_W:0]      free_last;

    cfl_ram #(.WIDTH($bits(flags_t)), .DEPTH(PAGE_COUNT)) u_flags (
        .aclk  (aclk),
        .we    (fl_we),
        .waddr (fl_waddr),
        .wdata (fl_wr),
        .raddr (addr_reg[ADDR_BITS-1:0]),
        .rdata (fl_rd)
    );

    cfl_ram #(.WIDTH(TXN_BITS), .DEPTH(PAGE_COUNT)) u_tags (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (paddr_reg),
        .wdata (txn_reg),
        .raddr (addr_reg[ADDR_BITS-1:0]),
        .rdata (tag_rd)
    );

    assign ready = (state_reg == S_IDLE);
    assign done  = (state_reg == S_RESP);
    assign res   = res_reg;

    assign issue     = (addr_reg <= {1'b0, end_reg});
    assign run_inc   = fl_rd.free ? run_reg + 1'b1 : '0;
    assign free_last = {1'b0, req.page_id} + {1'b0, req.overflow};

    // next state and register updates
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        n_next     = n_reg;
        txn_next   = txn_reg;
        first_next = first_reg;
        end_next   = end_reg;
        addr_next  = addr_reg;
        pvld_next  = 1'b0;
        paddr_next = addr_reg[ADDR_BITS-1:0];
        run_next   = run_reg;
        res_next   = res_reg;

        case (state_reg)
            S_CLEAR: begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg[ADDR_BITS-1:0] == LAST_PAGE) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    op_next    = req.operation;
                    n_next     = req.run_length;
                    txn_next   = req.txn_id[TXN_BITS-1:0];
                    run_next   = '0;
                    res_next   = '0;
                    addr_next  = '0;
                    first_next = '0;
                    end_next   = LAST_PAGE;
                    state_next = S_RESP;
                    case (req.operation)
                        OP_ALLOC: begin
                            if (req.run_length == '0 || 32'(req.run_length) > PAGE_COUNT) begin
                                res_next.status = ST_NORUN;
                            end else begin
                                state_next = S_CHECK;
                            end
                        end
                        OP_FREE: begin
                            if (req.page_id <= PAGE_W'(1)) begin
                                res_next.status = ST_RESERVED;
                            end else if (32'(free_last) >= PAGE_COUNT) begin
                                res_next.status = ST_RANGE;
                            end else begin
                                addr_next  = CNT_BITS'(req.page_id);
                                first_next = ADDR_BITS'(req.page_id);
                                end_next   = ADDR_BITS'(free_last);
                                state_next = S_CHECK;
                            end
                        end
                        OP_RELEASE, OP_ROLLBACK: begin
                            state_next = S_APPLY;
                        end
                        OP_QUERY: begin
                            if (32'(req.page_id) >= PAGE_COUNT) begin
                                res_next.status = ST_RANGE;
                            end else begin
                                addr_next  = CNT_BITS'(req.page_id);
                                end_next   = ADDR_BITS'(req.page_id);
                                state_next = S_APPLY;
                            end
                        end
                        OP_LOAD: begin
                            if (req.page_id <= PAGE_W'(1)) begin
                                res_next.status = ST_RESERVED;
                            end else if (32'(req.page_id) >= PAGE_COUNT) begin
                                res_next.status = ST_RANGE;
                            end else begin
                                addr_next  = CNT_BITS'(req.page_id);
                                end_next   = ADDR_BITS'(req.page_id);
                                state_next = S_APPLY;
                            end
                        end
                        default: begin
                            res_next.status = ST_RANGE;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                pvld_next = issue;
                if (issue) begin
                    addr_next = addr_reg + 1'b1;
                end
                if (pvld_reg) begin
                    if (op_reg == OP_ALLOC) begin
                        run_next = run_inc;
                        if (run_inc == n_reg) begin
                            first_next = ADDR_BITS'(RUN_W'(paddr_reg) + 1'b1 - n_reg);
                            res_next.start_page = PAGE_W'(RUN_W'(paddr_reg) + 1'b1 - n_reg);
                            addr_next  = CNT_BITS'(RUN_W'(paddr_reg) + 1'b1 - n_reg);
                            end_next   = paddr_reg;
                            pvld_next  = 1'b0;
                            state_next = S_APPLY;
                        end else if (paddr_reg == LAST_PAGE) begin
                            res_next.status = ST_NORUN;
                            pvld_next  = 1'b0;
                            state_next = S_RESP;
                        end
                    end else begin
                        if (fl_rd.freed) begin
                            res_next.status = ST_FREED;
                            pvld_next  = 1'b0;
                            state_next = S_RESP;
                        end else if (paddr_reg == end_reg) begin
                            addr_next  = CNT_BITS'(first_reg);
                            pvld_next  = 1'b0;
                            state_next = S_APPLY;
                        end
                    end
                end
            end
            S_APPLY: begin
                pvld_next = issue;
                if (issue) begin
                    addr_next = addr_reg + 1'b1;
                end
                if (pvld_reg) begin
                    if (op_reg == OP_QUERY) begin
                        res_next.is_freed = fl_rd.freed;
                    end
                    if (paddr_reg == end_reg) begin
                        pvld_next  = 1'b0;
                        state_next = S_RESP;
                    end
                end
            end
            S_RESP: begin
                if (done_ack) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory write side
    always_comb begin
        fl_we    = 1'b0;
        tag_we   = 1'b0;
        fl_waddr = paddr_reg;
        fl_wr    = fl_rd;
        case (state_reg)
            S_CLEAR: begin
                fl_we    = 1'b1;
                fl_waddr = addr_reg[ADDR_BITS-1:0];
                fl_wr    = '0;
            end
            S_APPLY: begin
                if (pvld_reg) begin
                    fl_we = 1'b1;
                    case (op_reg)
                        OP_ALLOC: begin
                            fl_wr.free  = 1'b0;
                            fl_wr.freed = 1'b0;
                        end
                        OP_FREE: begin
                            fl_wr.pend  = 1'b1;
                            fl_wr.freed = 1'b1;
                            tag_we      = 1'b1;
                        end
                        OP_RELEASE: begin
                            if (fl_rd.pend && tag_rd <= txn_reg) begin
                                fl_wr.pend = 1'b0;
                                fl_wr.free = 1'b1;
                            end
                        end
                        OP_ROLLBACK: begin
                            if (fl_rd.pend && tag_rd == txn_reg) begin
                                fl_wr.pend  = 1'b0;
                                fl_wr.freed = 1'b0;
                            end
                        end
                        OP_LOAD: begin
                            fl_wr.free  = 1'b1;
                            fl_wr.freed = 1'b1;
                        end
                        default: begin
                            fl_we = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                fl_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            addr_reg  <= '0;
            pvld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            pvld_reg  <= pvld_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        n_reg     <= n_next;
        txn_reg   <= txn_next;
        first_reg <= first_next;
        end_reg   <= end_next;
        paddr_reg <= paddr_next;
        run_reg   <= run_next;
        res_reg   <= res_next;
    end

endmodule

[rtl/core/contiguous_page_freelist.sv]
// First-fit allocator of contiguous page runs with transaction-tagged pending
// frees. Page flags (free, pending, freed) and the pending tags live in two
// simple dual-port RAMs with registered reads; every valid operation is a
// sweep over pages, one page per clock, that reads their flags and, except
// for query, writes them back. After reset the block clears all PAGE_COUNT
// (4096) entries of the flag RAM and holds s_tready low meanwhile. Query and
// load touch a single page; release and rollback sweep all pages; allocate
// scans up to the end of the first fitting run then clears it, or scans all
// pages when nothing fits; free checks then marks its range. One transaction
// is worked at a time; a finished result sits in the output register so the
// next transaction can be accepted before it is taken.
module contiguous_page_freelist
    import cfl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[2:0], run_length[15:3], txn_id[31:16], page_id[43:32],
    // overflow[55:44]
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // start_page[11:0], status[14:12], is_freed[15]
    output logic [15:0] m_tdata
);

    logic m_tvalid_reg, m_tvalid_next;
    res_t out_reg, out_next;
    logic eng_ready, eng_done, eng_ack;
    res_t eng_res;
    req_t req;

    assign req      = s_tdata;
    assign s_tready = eng_ready;

    // engine result moves into the output register once it is free
    assign eng_ack = eng_done && (!m_tvalid_reg || m_tready);

    cfl_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_tvalid && eng_ready),
        .req      (req),
        .ready    (eng_ready),
        .done     (eng_done),
        .done_ack (eng_ack),
        .res      (eng_res)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (eng_ack) begin
            m_tvalid_next = 1'b1;
            out_next      = eng_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

endmodule
